FILE: hw/rtl/pidc_pkg.sv
// Shared constants, widths and control types for the clamped PID controller.
`timescale 1ns / 1ps

package pidc_pkg;

    // Configuration register indexes
    localparam int          CFG_IDX_W     = 3;
    localparam int          CFG_DATA_W    = 32;
    localparam logic [2:0]  REG_GAIN_P    = 3'd0;
    localparam logic [2:0]  REG_GAIN_I    = 3'd1;
    localparam logic [2:0]  REG_GAIN_D    = 3'd2;
    localparam logic [2:0]  REG_INT_LIMIT = 3'd3;
    localparam logic [2:0]  REG_OUT_LIMIT = 3'd4;

    // Field and datapath widths
    localparam int GAIN_W   = 16;
    localparam int IN_W     = 16;
    localparam int ERR_W    = 17;
    localparam int DIFF_W   = 18;
    localparam int ACCUM_W  = 32;
    localparam int LIM_W    = 31;
    localparam int DRIVE_W  = 32;
    localparam int P0_W     = GAIN_W + ERR_W;
    localparam int P1_W     = GAIN_W + ACCUM_W;
    localparam int P2_W     = GAIN_W + DIFF_W;
    localparam int MAC_W    = 48;

    // Division by 25600 = 1024 * 25: shift, then reciprocal multiply by 25
    localparam int          SCALE_SHIFT = 10;
    localparam int          DIVIDEND_W  = MAC_W - 1 - SCALE_SHIFT;  // 37
    localparam int          SPLIT_W     = 18;
    localparam int          RECIP_W     = 32;
    localparam int          RECIP_SHIFT = 36;
    localparam logic [31:0] RECIP_25    = 32'd2748779069;           // floor(2^36 / 25)
    localparam int          QUOT_W      = 33;
    localparam int          REM_W       = 7;
    localparam logic [6:0]  DIV_ONE     = 7'd25;
    localparam logic [6:0]  DIV_TWO     = 7'd50;

    localparam logic [LIM_W-1:0] OUT_LIMIT_RESET = 31'h7FFF_FFFF;

    // Pipeline depth: input, error, products, sum, magnitude,
    // partial products, estimate, correction, output
    localparam int NUM_STAGES = 9;

    typedef struct packed {
        logic ld_in;      // load input register
        logic ld_err;     // load error stage
        logic upd_state;  // a valid request moves into the error stage
    } t_front_ctl;

endpackage

FILE: hw/rtl/pidc_ifs.sv
// Valid/ready channel interfaces for requests, results and configuration writes.
`timescale 1ns / 1ps

interface pidc_req_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pidc_pkg::IN_W-1:0]     measured;
    logic signed [pidc_pkg::IN_W-1:0]     setpoint;

    modport source (output valid, output measured, output setpoint, input ready);
    modport sink   (input valid, input measured, input setpoint, output ready);
endinterface

interface pidc_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pidc_pkg::DRIVE_W-1:0]  drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface pidc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [pidc_pkg::CFG_IDX_W-1:0]       index;
    logic [pidc_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/pidc_front.sv
// Input register, error, saturated/clamped integral and derivative stage with state.
`timescale 1ns / 1ps

module pidc_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  pidc_pkg::t_front_ctl                     i_ctl,
    input  logic signed [pidc_pkg::IN_W-1:0]         i_measured,
    input  logic signed [pidc_pkg::IN_W-1:0]         i_setpoint,
    input  logic [pidc_pkg::LIM_W-1:0]               i_int_limit,
    output logic signed [pidc_pkg::ERR_W-1:0]        o_err,
    output logic signed [pidc_pkg::ACCUM_W-1:0]      o_sum,
    output logic signed [pidc_pkg::DIFF_W-1:0]       o_diff
);

    localparam int ERR_W  = pidc_pkg::ERR_W;
    localparam int DIFF_W = pidc_pkg::DIFF_W;

    logic signed [pidc_pkg::IN_W-1:0]      r_measured;
    logic signed [pidc_pkg::IN_W-1:0]      r_setpoint;
    logic signed [pidc_pkg::ERR_W-1:0]     r_err,  n_err;
    logic signed [pidc_pkg::ACCUM_W-1:0]   r_sum,  n_sum;
    logic signed [pidc_pkg::DIFF_W-1:0]    r_diff, n_diff;
    logic signed [pidc_pkg::ACCUM_W-1:0]   r_accum;
    logic signed [pidc_pkg::ERR_W-1:0]     r_prev;
    logic signed [pidc_pkg::ACCUM_W:0]     sum_wide;
    logic signed [pidc_pkg::ACCUM_W-1:0]   sum_sat;
    logic signed [pidc_pkg::ACCUM_W-1:0]   lim_pos;
    logic signed [pidc_pkg::ACCUM_W-1:0]   lim_neg;

    // Hold the request fields
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_measured <= i_measured;
            r_setpoint <= i_setpoint;
        end
    end

    // Error, saturated sum with optional clamp, and difference
    always_comb begin
        n_err    = ERR_W'(r_measured) - ERR_W'(r_setpoint);
        sum_wide = (pidc_pkg::ACCUM_W + 1)'(r_accum) + (pidc_pkg::ACCUM_W + 1)'(n_err);
        if (sum_wide[pidc_pkg::ACCUM_W] != sum_wide[pidc_pkg::ACCUM_W-1]) begin
            sum_sat = sum_wide[pidc_pkg::ACCUM_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sum_sat = sum_wide[pidc_pkg::ACCUM_W-1:0];
        end
        lim_pos = $signed({1'b0, i_int_limit});
        lim_neg = -lim_pos;
        n_sum   = sum_sat;
        if (i_int_limit != '0) begin
            if (sum_sat > lim_pos) begin
                n_sum = lim_pos;
            end else if (sum_sat < lim_neg) begin
                n_sum = lim_neg;
            end
        end
        n_diff = DIFF_W'(n_err) - DIFF_W'(r_prev);
    end

    // Advance the error stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_err) begin
            r_err  <= n_err;
            r_sum  <= n_sum;
            r_diff <= n_diff;
        end
    end

    // Update the integral and previous error once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_prev  <= '0;
        end else if (i_ctl.upd_state) begin
            r_accum <= n_sum;
            r_prev  <= n_err;
        end
    end

    assign o_err  = r_err;
    assign o_sum  = r_sum;
    assign o_diff = r_diff;

endmodule

FILE: hw/rtl/pidc_mac.sv
// Gain products and their sum.
`timescale 1ns / 1ps

module pidc_mac (
    input  logic                                     i_clk,
    input  logic [1:0]                               i_en,
    input  logic signed [pidc_pkg::GAIN_W-1:0]       i_gain_p,
    input  logic signed [pidc_pkg::GAIN_W-1:0]       i_gain_i,
    input  logic signed [pidc_pkg::GAIN_W-1:0]       i_gain_d,
    input  logic signed [pidc_pkg::ERR_W-1:0]        i_err,
    input  logic signed [pidc_pkg::ACCUM_W-1:0]      i_sum,
    input  logic signed [pidc_pkg::DIFF_W-1:0]       i_diff,
    output logic signed [pidc_pkg::MAC_W-1:0]        o_acc
);

    logic signed [pidc_pkg::P0_W-1:0]   r_p0, n_p0;
    logic signed [pidc_pkg::P1_W-1:0]   r_p1, n_p1;
    logic signed [pidc_pkg::P2_W-1:0]   r_p2, n_p2;
    logic signed [pidc_pkg::MAC_W-1:0]  r_acc, n_acc;

    // Three independent products
    always_comb begin
        n_p0 = pidc_pkg::P0_W'(i_gain_p) * pidc_pkg::P0_W'(i_err);
        n_p1 = pidc_pkg::P1_W'(i_gain_i) * pidc_pkg::P1_W'(i_sum);
        n_p2 = pidc_pkg::P2_W'(i_gain_d) * pidc_pkg::P2_W'(i_diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
    end

    // Sum the products
    assign n_acc = pidc_pkg::MAC_W'(r_p0) + pidc_pkg::MAC_W'(r_p1)
                 + pidc_pkg::MAC_W'(r_p2);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: hw/rtl/pidc_div.sv
// Truncating division by 25600 and symmetric output clamp.
`timescale 1ns / 1ps

module pidc_div (
    input  logic                                     i_clk,
    input  logic [4:0]                               i_en,
    input  logic signed [pidc_pkg::MAC_W-1:0]        i_acc,
    input  logic [pidc_pkg::LIM_W-1:0]               i_out_limit,
    output logic signed [pidc_pkg::DRIVE_W-1:0]      o_drive
);

    localparam int HI_W = pidc_pkg::DIVIDEND_W - pidc_pkg::SPLIT_W;
    localparam int PH_W = HI_W + pidc_pkg::RECIP_W;
    localparam int PL_W = pidc_pkg::SPLIT_W + pidc_pkg::RECIP_W;
    localparam int PS_W = PH_W + pidc_pkg::SPLIT_W;
    localparam int M_W  = pidc_pkg::QUOT_W + 5;

    logic [pidc_pkg::MAC_W-1:0]        abs_acc;
    logic [pidc_pkg::DIVIDEND_W-1:0]   r_x4;
    logic                              r_neg4, r_neg5, r_neg6, r_neg7;
    logic [PH_W-1:0]                   r_ph, n_ph;
    logic [PL_W-1:0]                   r_pl, n_pl;
    logic [pidc_pkg::REM_W-1:0]        r_xlo5, r_xlo6;
    logic [PS_W-1:0]                   prod_sum;
    logic [pidc_pkg::QUOT_W-1:0]       r_qe, n_qe;
    logic [M_W-1:0]                    qe_x25;
    logic [pidc_pkg::REM_W-1:0]        rem;
    logic [pidc_pkg::QUOT_W-1:0]       r_q, n_q;
    logic [pidc_pkg::QUOT_W-1:0]       lim_wide;
    logic [pidc_pkg::QUOT_W-1:0]       mag;
    logic signed [pidc_pkg::DRIVE_W-1:0] r_drive, n_drive;

    // Take the magnitude and drop the power-of-two part of the scale
    assign abs_acc = i_acc[pidc_pkg::MAC_W-1] ? $unsigned(-i_acc) : $unsigned(i_acc);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x4   <= abs_acc[pidc_pkg::MAC_W-2:pidc_pkg::SCALE_SHIFT];
            r_neg4 <= i_acc[pidc_pkg::MAC_W-1];
        end
    end

    // Reciprocal partial products over the high and low halves
    always_comb begin
        n_ph = PH_W'(r_x4[pidc_pkg::DIVIDEND_W-1:pidc_pkg::SPLIT_W]) * PH_W'(pidc_pkg::RECIP_25);
        n_pl = PL_W'(r_x4[pidc_pkg::SPLIT_W-1:0]) * PL_W'(pidc_pkg::RECIP_25);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ph   <= n_ph;
            r_pl   <= n_pl;
            r_xlo5 <= r_x4[pidc_pkg::REM_W-1:0];
            r_neg5 <= r_neg4;
        end
    end

    // Combine the partial products into the quotient estimate
    assign prod_sum = {r_ph, {pidc_pkg::SPLIT_W{1'b0}}} + PS_W'(r_pl);
    assign n_qe     = prod_sum[pidc_pkg::RECIP_SHIFT + pidc_pkg::QUOT_W - 1:
                               pidc_pkg::RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_qe   <= n_qe;
            r_xlo6 <= r_xlo5;
            r_neg6 <= r_neg5;
        end
    end

    // Correct the estimate, which falls short by at most two
    always_comb begin
        qe_x25 = M_W'({r_qe, 4'b0}) + M_W'({r_qe, 3'b0}) + M_W'(r_qe);
        rem    = r_xlo6 - qe_x25[pidc_pkg::REM_W-1:0];
        if (rem >= pidc_pkg::DIV_TWO) begin
            n_q = r_qe + pidc_pkg::QUOT_W'(2);
        end else if (rem >= pidc_pkg::DIV_ONE) begin
            n_q = r_qe + pidc_pkg::QUOT_W'(1);
        end else begin
            n_q = r_qe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_q    <= n_q;
            r_neg7 <= r_neg6;
        end
    end

    // Clamp the magnitude and restore the sign
    always_comb begin
        lim_wide = pidc_pkg::QUOT_W'(i_out_limit);
        mag      = (r_q > lim_wide) ? lim_wide : r_q;
        n_drive  = r_neg7 ? -$signed(mag[pidc_pkg::DRIVE_W-1:0])
                          : $signed(mag[pidc_pkg::DRIVE_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

FILE: hw/rtl/pid_controller_clamped_core.sv
// Top level of the clamped PID controller: configuration, pipeline control, datapath.
//
//  channel  | dir | signals                            | accepted when
//  ---------+-----+------------------------------------+--------------------------
//  i_req    | in  | measured[15:0], setpoint[15:0]     | valid && ready
//  o_rsp    | out | drive[31:0]                        | valid && ready
//  i_cfg    | in  | index[2:0], data[31:0]             | valid && ready (ready = 1)
//
// One request per cycle is taken while any stage is empty or o_rsp is ready; each result
// is valid once its request has passed through every stage register.
// The pipeline runs input, error/integral, products, sum, magnitude, reciprocal
// partial products, estimate, correction and output clamp, one register each.
// A stall on o_rsp fills empty stages first, so requests keep flowing while bubbles remain.
// Synchronous active-low reset clears integral, previous error, stage valids, gains and int limit.
`timescale 1ns / 1ps

module pid_controller_clamped_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pidc_req_if.sink     i_req,
    pidc_rsp_if.source   o_rsp,
    pidc_cfg_if.sink     i_cfg
);

    localparam int NS = pidc_pkg::NUM_STAGES;

    logic signed [pidc_pkg::GAIN_W-1:0]  r_gain_p, r_gain_i, r_gain_d;
    logic [pidc_pkg::LIM_W-1:0]          r_int_limit, r_out_limit;
    logic [NS-1:0]                       r_vld;
    logic [NS-1:0]                       take;
    pidc_pkg::t_front_ctl                front_ctl;
    logic signed [pidc_pkg::ERR_W-1:0]   err;
    logic signed [pidc_pkg::ACCUM_W-1:0] sum;
    logic signed [pidc_pkg::DIFF_W-1:0]  diff;
    logic signed [pidc_pkg::MAC_W-1:0]   acc;

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_int_limit <= '0;
            r_out_limit <= pidc_pkg::OUT_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pidc_pkg::REG_GAIN_P:    r_gain_p    <= $signed(i_cfg.data[pidc_pkg::GAIN_W-1:0]);
                pidc_pkg::REG_GAIN_I:    r_gain_i    <= $signed(i_cfg.data[pidc_pkg::GAIN_W-1:0]);
                pidc_pkg::REG_GAIN_D:    r_gain_d    <= $signed(i_cfg.data[pidc_pkg::GAIN_W-1:0]);
                pidc_pkg::REG_INT_LIMIT: r_int_limit <= i_cfg.data[pidc_pkg::LIM_W-1:0];
                pidc_pkg::REG_OUT_LIMIT: r_out_limit <= i_cfg.data[pidc_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its content moves on
    always_comb begin
        take[NS-1] = !r_vld[NS-1] || o_rsp.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            take[k] = !r_vld[k] || take[k+1];
        end
    end

    // Advance the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (take[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_req.ready = take[0];
    assign o_rsp.valid = r_vld[NS-1];

    assign front_ctl.ld_in     = take[0];
    assign front_ctl.ld_err    = take[1];
    assign front_ctl.upd_state = take[1] && r_vld[0];

    pidc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (front_ctl),
        .i_measured  (i_req.measured),
        .i_setpoint  (i_req.setpoint),
        .i_int_limit (r_int_limit),
        .o_err       (err),
        .o_sum       (sum),
        .o_diff      (diff)
    );

    pidc_mac u_mac (
        .i_clk    (i_clk),
        .i_en     (take[3:2]),
        .i_gain_p (r_gain_p),
        .i_gain_i (r_gain_i),
        .i_gain_d (r_gain_d),
        .i_err    (err),
        .i_sum    (sum),
        .i_diff   (diff),
        .o_acc    (acc)
    );

    pidc_div u_div (
        .i_clk       (i_clk),
        .i_en        (take[8:4]),
        .i_acc       (acc),
        .i_out_limit (r_out_limit),
        .o_drive     (o_rsp.drive)
    );

endmodule

FILE: bench/tb_pid_controller_clamped_core.sv
// Self-checking testbench for the clamped PID controller core.
`timescale 1ns / 1ps

module tb_pid_controller_clamped_core;

    import pidc_pkg::*;

    localparam logic signed [IN_W-1:0]   IN_MAX   = 16'sh7FFF;
    localparam logic signed [IN_W-1:0]   IN_MIN   = 16'sh8000;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 16'sh7FFF;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = 16'sh8000;
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sh0100;
    localparam logic [LIM_W-1:0]         LIM_MAX  = 31'h7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = 3'd7;

    localparam longint SUM_MAX  = 64'sh7FFF_FFFF;
    localparam longint SUM_MIN  = -64'sh8000_0000;
    localparam longint OUT_DIV  = 25600;

    localparam int          WINDUP_ITEMS = 40;
    localparam int          RAND_GROUPS  = 10;
    localparam int          GROUP_ITEMS  = 30;
    localparam int          HOLD_GROUP   = 5;
    localparam int          HOLD_CYCLES  = 4 * NUM_STAGES + 8;
    localparam int unsigned RUN_LIMIT    = 1000000;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [LIM_W-1:0]         ilim;
        logic [LIM_W-1:0]         olim;
    } pid_setting_t;

    typedef struct packed {
        logic [2:0]                setting;
        logic signed [IN_W-1:0]    meas;
        logic signed [IN_W-1:0]    setp;
        logic                      known;
        logic signed [DRIVE_W-1:0] drive;
    } dir_row_t;

    localparam int DIR_SETTINGS_N = 7;
    localparam int DIR_COUNT      = 25;

    localparam pid_setting_t DIR_SETTINGS [DIR_SETTINGS_N] = '{
        '{16'sd0,   16'sd0,   16'sd0,   31'd0,   LIM_MAX},   // reset values
        '{GAIN_ONE, 16'sd0,   16'sd0,   31'd0,   LIM_MAX},   // drive = e / 100
        '{GAIN_MAX, GAIN_MAX, GAIN_MAX, 31'd0,   31'd0},     // zero output limit
        '{GAIN_ONE, 16'sd0,   GAIN_ONE, 31'd0,   LIM_MAX},   // derivative
        '{16'sd0,   GAIN_ONE, 16'sd0,   31'd300, LIM_MAX},   // integral clamp
        '{GAIN_MIN, GAIN_MIN, GAIN_MIN, LIM_MAX, LIM_MAX},   // most negative gains
        '{GAIN_MAX, 16'sd0,   16'sd0,   31'd0,   31'd5}      // output clamp
    };

    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        '{3'd0, 16'sd0,   16'sd0,   1'b1, 32'sd0},
        '{3'd0, IN_MAX,   IN_MIN,   1'b1, 32'sd0},
        '{3'd0, IN_MIN,   IN_MAX,   1'b1, 32'sd0},
        '{3'd0, -16'sd1,  -16'sd1,  1'b1, 32'sd0},
        '{3'd1, IN_MAX,   IN_MIN,   1'b1, 32'sd655},
        '{3'd1, IN_MIN,   IN_MAX,   1'b1, -32'sd655},
        '{3'd1, 16'sd150, 16'sd50,  1'b1, 32'sd1},
        '{3'd1, -16'sd99, 16'sd0,   1'b1, 32'sd0},
        '{3'd1, 16'sd0,   16'sd199, 1'b1, -32'sd1},
        '{3'd2, IN_MAX,   IN_MIN,   1'b1, 32'sd0},
        '{3'd2, IN_MIN,   IN_MAX,   1'b1, 32'sd0},
        '{3'd2, IN_MIN,   IN_MIN,   1'b1, 32'sd0},
        '{3'd3, 16'sd1000, 16'sd0,  1'b0, 32'sd0},
        '{3'd3, 16'sd1000, 16'sd0,  1'b0, 32'sd0},
        '{3'd3, IN_MIN,   IN_MAX,   1'b0, 32'sd0},
        '{3'd3, IN_MAX,   IN_MIN,   1'b0, 32'sd0},
        '{3'd4, IN_MAX,   IN_MIN,   1'b1, 32'sd3},
        '{3'd4, IN_MIN,   IN_MAX,   1'b1, -32'sd3},
        '{3'd4, 16'sd50,  16'sd0,   1'b1, -32'sd2},
        '{3'd4, 16'sd300, 16'sd0,   1'b1, 32'sd0},
        '{3'd5, IN_MAX,   IN_MIN,   1'b0, 32'sd0},
        '{3'd5, IN_MIN,   IN_MAX,   1'b0, 32'sd0},
        '{3'd5, 16'sd123, -16'sd456, 1'b0, 32'sd0},
        '{3'd6, IN_MAX,   IN_MIN,   1'b1, 32'sd5},
        '{3'd6, IN_MIN,   IN_MAX,   1'b1, -32'sd5}
    };

    logic clk;
    logic rst_n;

    pidc_req_if req_if ();
    pidc_rsp_if rsp_if ();
    pidc_cfg_if cfg_if ();

    pid_controller_clamped_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Shadow of the controller state and its registers
    logic signed [ACCUM_W-1:0] accum_q    = '0;
    logic signed [ERR_W-1:0]   prev_err_q = '0;
    logic signed [GAIN_W-1:0]  kp_q       = '0;
    logic signed [GAIN_W-1:0]  ki_q       = '0;
    logic signed [GAIN_W-1:0]  kd_q       = '0;
    logic [LIM_W-1:0]          ilim_q     = '0;
    logic [LIM_W-1:0]          olim_q     = OUT_LIMIT_RESET;

    logic signed [DRIVE_W-1:0] pending_drives [$];
    logic signed [DRIVE_W-1:0] oldest_drive;
    int unsigned               fault_count = 0;
    int unsigned               cycle_count = 0;
    bit                        idle_on     = 1'b1;
    bit                        hold_req    = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One PID step on the shadow state; returns the clamped drive
    function automatic logic signed [DRIVE_W-1:0] predict_drive(
        input logic signed [IN_W-1:0] meas,
        input logic signed [IN_W-1:0] setp
    );
        longint err;
        longint total;
        longint delta;
        longint mac;
        longint quo;
        err   = longint'(meas) - longint'(setp);
        total = longint'(accum_q) + err;
        delta = err - longint'(prev_err_q);
        if (total > SUM_MAX) total = SUM_MAX;
        if (total < SUM_MIN) total = SUM_MIN;
        if (ilim_q != '0) begin
            if (total > longint'(ilim_q)) total = longint'(ilim_q);
            else if (total < -longint'(ilim_q)) total = -longint'(ilim_q);
        end
        accum_q    = total[ACCUM_W-1:0];
        prev_err_q = err[ERR_W-1:0];
        mac = longint'(kp_q) * err + longint'(ki_q) * total + longint'(kd_q) * delta;
        quo = mac / OUT_DIV;
        if (quo > longint'(olim_q)) quo = longint'(olim_q);
        else if (quo < -longint'(olim_q)) quo = -longint'(olim_q);
        return quo[DRIVE_W-1:0];
    endfunction

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return GAIN_MIN;
            1: return GAIN_MAX;
            2: return '0;
            3: return GAIN_ONE;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return LIM_MAX;
            2: return LIM_W'($urandom_range(1, 2000));
            3: return LIM_W'($urandom_range(1, 300000));
            default: return LIM_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [IN_W-1:0] pick_input();
        case ($urandom_range(0, 7))
            0: return IN_MAX;
            1: return IN_MIN;
            2: return IN_W'(int'($urandom_range(0, 400)) - 200);
            default: return IN_W'($urandom);
        endcase
    endfunction

    function automatic pid_setting_t random_setting();
        pid_setting_t s;
        s.kp   = pick_gain();
        s.ki   = pick_gain();
        s.kd   = pick_gain();
        s.ilim = pick_limit();
        s.olim = pick_limit();
        return s;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("drive check: %s", msg);
    endtask

    // Offer one request from a falling edge; return at the falling edge after acceptance
    task automatic send_request(
        input logic signed [IN_W-1:0]    meas,
        input logic signed [IN_W-1:0]    setp,
        input logic                      known,
        input logic signed [DRIVE_W-1:0] known_drive
    );
        logic signed [DRIVE_W-1:0] model_drive;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.measured <= meas;
        req_if.setpoint <= setp;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        model_drive = predict_drive(meas, setp);
        pending_drives.push_back(known ? known_drive : model_drive);
        @(negedge clk);
    endtask

    // Drop the request line and wait until every drive has come back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_drives.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (idx)
            REG_GAIN_P:    kp_q   = value[GAIN_W-1:0];
            REG_GAIN_I:    ki_q   = value[GAIN_W-1:0];
            REG_GAIN_D:    kd_q   = value[GAIN_W-1:0];
            REG_INT_LIMIT: ilim_q = value[LIM_W-1:0];
            REG_OUT_LIMIT: olim_q = value[LIM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Write all five registers, with junk in the unused upper bits
    task automatic apply_settings(input pid_setting_t s);
        // an index past the last register must be dropped
        write_reg(CFG_IDX_W'($urandom_range(REG_OUT_LIMIT + 1, REG_LAST_INDEX)), $urandom);
        write_reg(REG_GAIN_P,    {16'($urandom), s.kp});
        write_reg(REG_GAIN_I,    {16'($urandom), s.ki});
        write_reg(REG_GAIN_D,    {16'($urandom), s.kd});
        write_reg(REG_INT_LIMIT, {1'($urandom), s.ilim});
        write_reg(REG_OUT_LIMIT, {1'($urandom), s.olim});
        cfg_if.valid <= 1'b0;
    endtask

    // Pace the result side: short random stalls, and one long hold-off on request
    initial begin : drive_pacing
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b1;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Compare each returned drive with the oldest one pending
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
            if (pending_drives.size() == 0) begin
                note_fault($sformatf("drive %0d returned with none pending", rsp_if.drive));
            end else begin
                oldest_drive = pending_drives.pop_front();
                if (rsp_if.drive !== oldest_drive)
                    note_fault($sformatf("expected %0d, got %0d", oldest_drive, rsp_if.drive));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned  cur;
        pid_setting_t s;
        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.measured <= '0;
        req_if.setpoint <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= '0;
        cfg_if.data     <= '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table, reprogramming between its phases
        cur = 0;
        for (int r = 0; r < DIR_COUNT; r++) begin
            if (DIR_ROWS[r].setting != cur) begin
                drain();
                cur = DIR_ROWS[r].setting;
                apply_settings(DIR_SETTINGS[cur]);
            end
            send_request(DIR_ROWS[r].meas, DIR_ROWS[r].setp,
                         DIR_ROWS[r].known, DIR_ROWS[r].drive);
        end

        // Push the error sum hard one way and then back at full rate
        drain();
        idle_on = 1'b0;
        s      = random_setting();
        s.ki   = GAIN_MAX;
        s.ilim = '0;
        s.olim = LIM_MAX;
        apply_settings(s);
        repeat (WINDUP_ITEMS) send_request(IN_MAX, IN_MIN, 1'b0, '0);
        repeat (2 * WINDUP_ITEMS) send_request(IN_MIN, IN_MAX, 1'b0, '0);

        // Random groups, each under a fresh setting; the tail runs without idling
        idle_on = 1'b1;
        for (int g = 0; g < RAND_GROUPS; g++) begin
            drain();
            if (g >= RAND_GROUPS - 3) idle_on = 1'b0;
            apply_settings(random_setting());
            if (g == HOLD_GROUP) hold_req = 1'b1;
            repeat (GROUP_ITEMS) send_request(pick_input(), pick_input(), 1'b0, '0);
        end

        drain();
        repeat (4 * NUM_STAGES) @(negedge clk);
        if (pending_drives.size() != 0)
            note_fault($sformatf("%0d drives never returned", pending_drives.size()));
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
